>>> design/tiered_random_slot_allocator_defines.svh
// Assertion macros for the tiered random slot allocator
`ifndef TIERED_RANDOM_SLOT_ALLOCATOR_DEFINES_SVH
`define TIERED_RANDOM_SLOT_ALLOCATOR_DEFINES_SVH

// check a consequence in the same cycle
`define TRSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the next cycle
`define TRSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/trsa_pkg.sv
// Package with types, constants and helpers for the tiered random slot allocator
`default_nettype none

package trsa_pkg;

    localparam int MAX_TIERS_DEF = 8;
    localparam int SLOT_STEP_DEF = 4;

    localparam int TIER_W  = 3;
    localparam int SLOT_W  = 5;
    localparam int PICK_W  = 8;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 4;
    localparam int MAP_W   = 32;
    localparam int CNT_W   = 6;
    localparam int CHUNK_W = 4;
    localparam int CHUNK_N = MAP_W / CHUNK_W;
    localparam int CHUNK_AW = $clog2(CHUNK_N);
    localparam int CHUNK_BW = $clog2(CHUNK_W);

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    localparam logic [CFG_W-1:0] TIERS_RESET = 4'd8;

    typedef struct packed {
        logic              mode;
        logic [PICK_W-1:0] random_pick;
        logic [TIER_W-1:0] tier_index;
        logic [SLOT_W-1:0] slot_index;
    } t_alloc_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TIER_W-1:0] granted_tier;
        logic [SLOT_W-1:0] granted_slot;
    } t_alloc_rsp;

    typedef struct packed {
        logic [MAP_W-1:0] map;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [TIER_W-1:0] addr;
        t_entry            wr_data;
    } t_mem_req;

    function automatic logic [CNT_W-1:0] tier_size(input logic [TIER_W-1:0] tier,
                                                   input int step);
        return CNT_W'(step * (int'(tier) + 1));
    endfunction

endpackage

`default_nettype wire

>>> design/trsa_tier_store.sv
// Per-tier occupancy map and free count memory with reset-value substitution
`default_nettype none

module trsa_tier_store #(
    parameter int MAX_TIERS = trsa_pkg::MAX_TIERS_DEF,
    parameter int SLOT_STEP = trsa_pkg::SLOT_STEP_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire trsa_pkg::t_mem_req i_req,
    output trsa_pkg::t_entry       o_entry
);

    localparam int TIER_AW = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1;

    trsa_pkg::t_entry                r_mem [MAX_TIERS];
    logic [MAX_TIERS-1:0]            r_vld;
    trsa_pkg::t_entry                r_rd_data;
    logic                            r_rd_vld;
    logic [trsa_pkg::TIER_W-1:0]     r_rd_tier;
    logic [TIER_AW-1:0]              addr;

    assign addr = i_req.addr[TIER_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[addr];
            r_rd_tier <= i_req.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[addr];
            end
        end
    end

    always_comb begin
        if (r_rd_vld) begin
            o_entry = r_rd_data;
        end else begin
            o_entry.map   = '0;
            o_entry.count = trsa_pkg::tier_size(r_rd_tier, SLOT_STEP);
        end
    end

endmodule

`default_nettype wire

>>> design/tiered_random_slot_allocator.sv
// Steps: a bad release by range or an allocate with no free tier goes straight to the result;
// a release does one memory read, then write-back; an allocate does one memory read, an 8-step
// remainder by the free count, then a 4-slot-per-cycle free slot scan of up to 8 steps with write-back.
// One request in flight; the next request is taken the cycle after the result is registered.
// Reset: synchronous, active low; per-tier valid bits make all slots free at once, no sweep.
// Tiers in use resets to 8.
`default_nettype none

`include "tiered_random_slot_allocator_defines.svh"

module tiered_random_slot_allocator #(
    parameter int MAX_TIERS = trsa_pkg::MAX_TIERS_DEF,
    parameter int SLOT_STEP = trsa_pkg::SLOT_STEP_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire trsa_pkg::t_alloc_req         i_in_req,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output trsa_pkg::t_alloc_rsp              o_out_rsp,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [trsa_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int TIER_AW = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MOD,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state                             r_state;
    trsa_pkg::t_alloc_req               r_req;
    logic [trsa_pkg::TIER_W-1:0]        r_tier;
    logic [trsa_pkg::MAP_W-1:0]         r_map;
    logic [trsa_pkg::CNT_W-1:0]         r_cnt;
    logic [trsa_pkg::CNT_W-1:0]         r_rem;
    logic [trsa_pkg::PICK_W-1:0]        r_dvd;
    logic [2:0]                         r_step;
    logic [trsa_pkg::CHUNK_AW-1:0]      r_chunk;
    trsa_pkg::t_alloc_rsp               r_res;
    trsa_pkg::t_alloc_rsp               r_out;
    logic                               r_out_valid;
    logic [trsa_pkg::CFG_W-1:0]         r_tiers;
    logic [MAX_TIERS-1:0]               r_full;

    trsa_pkg::t_mem_req                 mem_req;
    trsa_pkg::t_entry                   entry;

    logic                               in_acc;
    logic [trsa_pkg::CFG_W-1:0]         limit;
    logic                               alloc_found;
    logic [trsa_pkg::TIER_W-1:0]        alloc_tier;
    logic                               rel_bad_range;
    logic                               rel_held;
    logic [trsa_pkg::CNT_W-1:0]         shifted;
    logic                               sub_ok;
    logic [trsa_pkg::CHUNK_W-1:0]       nib_free;
    logic [trsa_pkg::CHUNK_BW:0]        nib_pc;
    logic [trsa_pkg::CHUNK_BW-1:0]      nib_pos;
    logic                               nib_hit;
    logic [trsa_pkg::SLOT_W-1:0]        scan_slot;

    trsa_tier_store #(
        .MAX_TIERS (MAX_TIERS),
        .SLOT_STEP (SLOT_STEP)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_entry (entry)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign limit = (r_tiers > trsa_pkg::CFG_W'(MAX_TIERS)) ?
                   trsa_pkg::CFG_W'(MAX_TIERS) : r_tiers;

    always_comb begin
        alloc_found = 1'b0;
        alloc_tier  = '0;
        for (int t = 0; t < MAX_TIERS; t++) begin
            if (!alloc_found && (trsa_pkg::CFG_W'(t) < limit) && !r_full[t]) begin
                alloc_found = 1'b1;
                alloc_tier  = trsa_pkg::TIER_W'(t);
            end
        end
    end

    assign rel_bad_range =
        ({1'b0, i_in_req.tier_index} >= (trsa_pkg::TIER_W + 1)'(MAX_TIERS)) ||
        ({1'b0, i_in_req.slot_index} >=
         trsa_pkg::tier_size(i_in_req.tier_index, SLOT_STEP));

    assign rel_held = entry.map[r_req.slot_index];

    assign shifted = {r_rem[trsa_pkg::CNT_W-2:0], r_dvd[trsa_pkg::PICK_W-1]};
    assign sub_ok  = (shifted >= r_cnt);

    assign nib_free = ~r_map[{r_chunk, {trsa_pkg::CHUNK_BW{1'b0}}} +: trsa_pkg::CHUNK_W];

    always_comb begin
        nib_pc  = '0;
        nib_pos = '0;
        nib_hit = 1'b0;
        for (int i = 0; i < trsa_pkg::CHUNK_W; i++) begin
            if (nib_free[i]) begin
                if (!nib_hit && ({{(trsa_pkg::CNT_W - trsa_pkg::CHUNK_BW - 1){1'b0}}, nib_pc}
                                 == r_rem)) begin
                    nib_hit = 1'b1;
                    nib_pos = trsa_pkg::CHUNK_BW'(i);
                end
                nib_pc = nib_pc + 1'b1;
            end
        end
    end

    assign scan_slot = {r_chunk, nib_pos};

    always_comb begin
        mem_req         = '0;
        mem_req.addr    = r_tier;
        mem_req.wr_data = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_req.mode == trsa_pkg::MODE_RELEASE) begin
                        mem_req.rd_en = !rel_bad_range;
                        mem_req.addr  = i_in_req.tier_index;
                    end else begin
                        mem_req.rd_en = alloc_found;
                        mem_req.addr  = alloc_tier;
                    end
                end
            end
            ST_LOOKUP: begin
                if (r_req.mode == trsa_pkg::MODE_RELEASE && rel_held) begin
                    mem_req.wr_en         = 1'b1;
                    mem_req.wr_data.map   = entry.map &
                                            ~(trsa_pkg::MAP_W'(1) << r_req.slot_index);
                    mem_req.wr_data.count = entry.count + 1'b1;
                end
            end
            ST_SCAN: begin
                if (nib_hit) begin
                    mem_req.wr_en         = 1'b1;
                    mem_req.wr_data.map   = r_map | (trsa_pkg::MAP_W'(1) << scan_slot);
                    mem_req.wr_data.count = r_cnt - 1'b1;
                end
            end
            ST_MOD, ST_FINISH: begin
                mem_req.rd_en = 1'b0;
            end
            default: begin
                mem_req.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_tiers     <= trsa_pkg::TIERS_RESET;
            r_full      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tiers <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_req <= i_in_req;
                        if (i_in_req.mode == trsa_pkg::MODE_RELEASE) begin
                            r_tier <= i_in_req.tier_index;
                            if (rel_bad_range) begin
                                r_res   <= {trsa_pkg::ST_BAD,
                                            {(trsa_pkg::TIER_W + trsa_pkg::SLOT_W){1'b0}}};
                                r_state <= ST_FINISH;
                            end else begin
                                r_res   <= '0;
                                r_state <= ST_LOOKUP;
                            end
                        end else begin
                            r_tier <= alloc_tier;
                            if (alloc_found) begin
                                r_res   <= '0;
                                r_state <= ST_LOOKUP;
                            end else begin
                                r_res   <= {trsa_pkg::ST_FULL,
                                            {(trsa_pkg::TIER_W + trsa_pkg::SLOT_W){1'b0}}};
                                r_state <= ST_FINISH;
                            end
                        end
                    end
                end
                ST_LOOKUP: begin
                    r_map <= entry.map;
                    r_cnt <= entry.count;
                    if (r_req.mode == trsa_pkg::MODE_RELEASE) begin
                        if (rel_held) begin
                            r_full[r_tier[TIER_AW-1:0]] <= 1'b0;
                        end else begin
                            r_res <= {trsa_pkg::ST_BAD,
                                      {(trsa_pkg::TIER_W + trsa_pkg::SLOT_W){1'b0}}};
                        end
                        r_state <= ST_FINISH;
                    end else begin
                        r_rem   <= '0;
                        r_dvd   <= r_req.random_pick;
                        r_step  <= '1;
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    r_rem   <= sub_ok ? (shifted - r_cnt) : shifted;
                    r_dvd   <= {r_dvd[trsa_pkg::PICK_W-2:0], 1'b0};
                    r_step  <= r_step - 1'b1;
                    r_chunk <= '0;
                    if (r_step == '0) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (nib_hit) begin
                        r_res <= {trsa_pkg::ST_OK, r_tier, scan_slot};
                        if (r_cnt == trsa_pkg::CNT_W'(1)) begin
                            r_full[r_tier[TIER_AW-1:0]] <= 1'b1;
                        end
                        r_state <= ST_FINISH;
                    end else begin
                        r_rem   <= r_rem - trsa_pkg::CNT_W'(nib_pc);
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `TRSA_ASSERT_NOW(a_grant_zero_unless_ok, i_clk, i_rst_n,
        o_out_valid && (o_out_rsp.status != trsa_pkg::ST_OK),
        (o_out_rsp.granted_tier == '0) && (o_out_rsp.granted_slot == '0),
        "grant fields nonzero on a failed request")
    `TRSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        in_acc, o_in_stall, "request taken while another is in flight")
    `TRSA_ASSERT_NOW(a_status_code, i_clk, i_rst_n,
        o_out_valid,
        (o_out_rsp.status == trsa_pkg::ST_OK) || (o_out_rsp.status == trsa_pkg::ST_FULL) ||
        (o_out_rsp.status == trsa_pkg::ST_BAD),
        "undefined status code")
    `TRSA_ASSERT_NOW(a_grant_in_range, i_clk, i_rst_n,
        o_out_valid && (o_out_rsp.status == trsa_pkg::ST_OK) && (r_state == ST_IDLE),
        {1'b0, o_out_rsp.granted_tier} < (trsa_pkg::TIER_W + 1)'(MAX_TIERS),
        "granted tier outside the tier range")

endmodule

`default_nettype wire

>>> verif/tb_tiered_random_slot_allocator.sv
// Testbench for the tiered random slot allocator: random and directed requests against a predictor
`timescale 1ns / 100ps

module tb_tiered_random_slot_allocator;

    localparam int TIER_COUNT     = trsa_pkg::MAX_TIERS_DEF;
    localparam int SLOTS_PER_STEP = trsa_pkg::SLOT_STEP_DEF;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 80;
    localparam int STALL_LIMIT    = 2000;
    localparam int IDLE_PCT       = 38;

    class slot_ledger;
        logic [trsa_pkg::MAP_W-1:0]  held_map [TIER_COUNT];
        int unsigned                 free_slots [TIER_COUNT];
        logic [trsa_pkg::CFG_W-1:0]  tiers_on;
        trsa_pkg::t_alloc_rsp        awaited_grants [$];
        int                          errors;

        function new();
            for (int t = 0; t < TIER_COUNT; t++) begin
                held_map[t]   = '0;
                free_slots[t] = tier_slots(t);
            end
            tiers_on = trsa_pkg::TIERS_RESET;
            errors   = 0;
        endfunction

        function int tier_slots(int t);
            return SLOTS_PER_STEP * (t + 1);
        endfunction

        function void set_tiers(logic [trsa_pkg::CFG_W-1:0] v);
            tiers_on = v;
        endfunction

        function void note_request(trsa_pkg::t_alloc_req req);
            trsa_pkg::t_alloc_rsp rsp;
            int                   limit;
            int                   k;
            int                   seen;
            bit                   found;
            rsp   = '0;
            found = 1'b0;
            if (req.mode == trsa_pkg::MODE_ALLOC) begin
                limit = (tiers_on > TIER_COUNT) ? TIER_COUNT : int'(tiers_on);
                for (int t = 0; t < limit && !found; t++) begin
                    if (free_slots[t] != 0) begin
                        k    = int'(req.random_pick) % free_slots[t];
                        seen = 0;
                        for (int s = 0; s < tier_slots(t) && !found; s++) begin
                            if (!held_map[t][s]) begin
                                if (seen == k) begin
                                    held_map[t][s] = 1'b1;
                                    free_slots[t]--;
                                    rsp.granted_tier = trsa_pkg::TIER_W'(t);
                                    rsp.granted_slot = trsa_pkg::SLOT_W'(s);
                                    found = 1'b1;
                                end
                                seen++;
                            end
                        end
                    end
                end
                rsp.status = found ? trsa_pkg::ST_OK : trsa_pkg::ST_FULL;
            end else if (int'(req.tier_index) >= TIER_COUNT ||
                         int'(req.slot_index) >= tier_slots(req.tier_index) ||
                         !held_map[req.tier_index][req.slot_index]) begin
                rsp.status = trsa_pkg::ST_BAD;
            end else begin
                held_map[req.tier_index][req.slot_index] = 1'b0;
                free_slots[req.tier_index]++;
                rsp.status = trsa_pkg::ST_OK;
            end
            awaited_grants.insert(awaited_grants.size(), rsp);
        endfunction

        function void check_grant(trsa_pkg::t_alloc_rsp got);
            trsa_pkg::t_alloc_rsp want;
            if (awaited_grants.size() == 0) begin
                $error("unexpected response %p", got);
                errors++;
                return;
            end
            want = awaited_grants.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.granted_tier !== want.granted_tier) begin
                $error("granted_tier expected %0d actual %0d",
                       want.granted_tier, got.granted_tier);
                errors++;
            end
            if (got.granted_slot !== want.granted_slot) begin
                $error("granted_slot expected %0d actual %0d",
                       want.granted_slot, got.granted_slot);
                errors++;
            end
        endfunction

        function bit find_held(output logic [trsa_pkg::TIER_W-1:0] tier,
                               output logic [trsa_pkg::SLOT_W-1:0] slot);
            logic [trsa_pkg::TIER_W+trsa_pkg::SLOT_W-1:0] held [$];
            int                                           idx;
            tier = '0;
            slot = '0;
            for (int t = 0; t < TIER_COUNT; t++) begin
                for (int s = 0; s < tier_slots(t); s++) begin
                    if (held_map[t][s]) begin
                        held.insert(held.size(),
                                    {trsa_pkg::TIER_W'(t), trsa_pkg::SLOT_W'(s)});
                    end
                end
            end
            if (held.size() == 0) begin
                return 1'b0;
            end
            idx = $urandom_range(0, held.size() - 1);
            {tier, slot} = held[idx];
            return 1'b1;
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    trsa_pkg::t_alloc_req       in_req    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    trsa_pkg::t_alloc_rsp       out_rsp;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [trsa_pkg::CFG_W-1:0] cfg_data  = '0;

    slot_ledger ledger = new();
    bit         quiet     = 1'b0;
    bit         hold_req  = 1'b0;
    int         idle_cycles = 0;

    int unsigned phase_tiers [8] = '{8, 3, 1, 15, 0, 6, 2, 8};
    int unsigned phase_items [8] = '{300, 150, 100, 250, 40, 200, 120, 240};

    tiered_random_slot_allocator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, one long hold-off on demand
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            ledger.check_grant(out_rsp);
        end
    end

    always @(negedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tiered_random_slot_allocator verification failed");
            $finish;
        end
    end

    task automatic send_req(input trsa_pkg::t_alloc_req r);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(negedge clk); while (in_stall);
        ledger.note_request(r);
        @(posedge clk);
    endtask

    task automatic alloc_req(input logic [trsa_pkg::PICK_W-1:0] pick);
        trsa_pkg::t_alloc_req r;
        r.mode        = trsa_pkg::MODE_ALLOC;
        r.random_pick = pick;
        r.tier_index  = trsa_pkg::TIER_W'($urandom);
        r.slot_index  = trsa_pkg::SLOT_W'($urandom);
        send_req(r);
    endtask

    task automatic release_req(input logic [trsa_pkg::TIER_W-1:0] tier,
                               input logic [trsa_pkg::SLOT_W-1:0] slot);
        trsa_pkg::t_alloc_req r;
        r.mode        = trsa_pkg::MODE_RELEASE;
        r.random_pick = trsa_pkg::PICK_W'($urandom);
        r.tier_index  = tier;
        r.slot_index  = slot;
        send_req(r);
    endtask

    task automatic release_held();
        logic [trsa_pkg::TIER_W-1:0] tier;
        logic [trsa_pkg::SLOT_W-1:0] slot;
        if (ledger.find_held(tier, slot)) begin
            release_req(tier, slot);
        end else begin
            alloc_req(trsa_pkg::PICK_W'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (ledger.awaited_grants.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tiers(input logic [trsa_pkg::CFG_W-1:0] v);
        in_valid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        ledger.set_tiers(v);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        bit fill;
        int seg_left;
        int r;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, then a single tier filled to the brim
        alloc_req(8'h00);
        write_tiers(4'd1);
        alloc_req(8'hFF);
        alloc_req(8'hAA);
        alloc_req(8'h55);
        alloc_req(8'h01);
        release_req(3'd0, 5'd0);
        release_req(3'd0, 5'd0);
        release_req(3'd0, 5'd4);
        release_req(3'd0, 5'd31);
        release_req(3'd7, 5'd31);
        release_req(3'd7, 5'd0);
        write_tiers(4'd0);
        alloc_req(8'hFF);
        write_tiers(4'd15);
        alloc_req(8'hFF);
        alloc_req(8'h00);
        alloc_req(8'h80);
        release_held();
        release_held();

        fill     = 1'b0;
        seg_left = 0;
        for (int p = 0; p < 8; p++) begin
            write_tiers(trsa_pkg::CFG_W'(phase_tiers[p]));
            quiet = (p == 3);
            if (p == 1) begin
                hold_req = 1'b1;
            end
            for (int i = 0; i < phase_items[p]; i++) begin
                if (seg_left == 0) begin
                    fill     = !fill;
                    seg_left = $urandom_range(30, 160);
                end
                seg_left--;
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    release_req(trsa_pkg::TIER_W'($urandom), trsa_pkg::SLOT_W'($urandom));
                end else if ((r < 82) == fill) begin
                    alloc_req(trsa_pkg::PICK_W'($urandom));
                end else begin
                    release_held();
                end
            end
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        wait_idle();
        if (ledger.errors == 0 && ledger.awaited_grants.size() == 0) begin
            $display("tiered_random_slot_allocator verification clean");
        end else begin
            $display("tiered_random_slot_allocator verification failed");
        end
        $finish;
    end

endmodule
